// ===== sv/ray_wall_shadow_test_top_assert.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the ray wall shadow test block.
// Each macro expects clk and rst_n in the scope where it is used.
// -----------------------------------------------------------------------------
`ifndef RAY_WALL_SHADOW_TEST_TOP_ASSERT_SVH
`define RAY_WALL_SHADOW_TEST_TOP_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define RWST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define RWST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rwst_pkg.sv =====
// -----------------------------------------------------------------------------
// rwst_pkg
// Widths, codes, pipeline tags and arithmetic helpers of the shadow test.
// -----------------------------------------------------------------------------
`default_nettype none

package rwst_pkg;

  // Table geometry.
  localparam int WALLS  = 64;
  localparam int SLOT_W = $clog2(WALLS);
  localparam int CNT_W  = $clog2(WALLS + 1);

  // Field widths.
  localparam int CRD_W  = 16;              // Q12.4 coordinate
  localparam int DIR_W  = 16;              // Q1.14 direction
  localparam int WALL_W = 4 * CRD_W;       // packed table entry
  localparam int DIF_W  = CRD_W + 1;       // coordinate difference
  localparam int PRD_W  = 2 * DIF_W;       // product of two differences
  localparam int SUM_W  = PRD_W + 1;       // difference of two products

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SUN_DIR_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUN_DIR_Z  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUN_UP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_COUNT = 2'd3;

  localparam logic signed [DIR_W-1:0] SUN_DIR_X_RST = 16'sd16384;
  localparam logic signed [DIR_W-1:0] SUN_DIR_Z_RST = 16'sd0;

  // Input opcodes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Tag that travels with each wall through the test pipeline.
  typedef struct packed {
    logic              vld;
    logic              last;
    logic [SLOT_W-1:0] idx;
  } rwst_tag_t;

  // Verdict for one wall at the end of the pipeline.
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic              last;
    logic [SLOT_W-1:0] idx;
  } rwst_hit_t;

  // Signed difference of two coordinates, one bit wider.
  function automatic logic signed [DIF_W-1:0] sdiff(logic signed [CRD_W-1:0] a,
                                                    logic signed [CRD_W-1:0] b);
    logic signed [DIF_W-1:0] ea;
    logic signed [DIF_W-1:0] eb;
    ea = {a[CRD_W-1], a};
    eb = {b[CRD_W-1], b};
    return ea - eb;
  endfunction

  // Exact signed product of two difference-width operands.
  function automatic logic signed [PRD_W-1:0] smul(logic signed [DIF_W-1:0] a,
                                                   logic signed [DIF_W-1:0] b);
    logic signed [PRD_W-1:0] ea;
    logic signed [PRD_W-1:0] eb;
    ea = {{(PRD_W-DIF_W){a[DIF_W-1]}}, a};
    eb = {{(PRD_W-DIF_W){b[DIF_W-1]}}, b};
    return ea * eb;
  endfunction

  // Exact signed difference of two products.
  function automatic logic signed [SUM_W-1:0] ssub(logic signed [PRD_W-1:0] a,
                                                   logic signed [PRD_W-1:0] b);
    logic signed [SUM_W-1:0] ea;
    logic signed [SUM_W-1:0] eb;
    ea = {a[PRD_W-1], a};
    eb = {b[PRD_W-1], b};
    return ea - eb;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rwst_in_if.sv =====
// -----------------------------------------------------------------------------
// rwst_in_if
// Input channel: wall loads and ground point queries.
// -----------------------------------------------------------------------------
`default_nettype none

interface rwst_in_if import rwst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [SLOT_W-1:0]       wall_slot;
  logic signed [CRD_W-1:0] start_x;
  logic signed [CRD_W-1:0] start_y;
  logic signed [CRD_W-1:0] end_x;
  logic signed [CRD_W-1:0] end_y;
  logic signed [CRD_W-1:0] point_x;
  logic signed [CRD_W-1:0] point_y;

  modport source (output valid, opcode, wall_slot, start_x, start_y, end_x, end_y,
                  point_x, point_y, input ready);
  modport sink   (input valid, opcode, wall_slot, start_x, start_y, end_x, end_y,
                  point_x, point_y, output ready);
endinterface

`default_nettype wire

// ===== sv/rwst_out_if.sv =====
// -----------------------------------------------------------------------------
// rwst_out_if
// Result channel: lit flag and index of the first blocking wall.
// -----------------------------------------------------------------------------
`default_nettype none

interface rwst_out_if import rwst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              lit;
  logic [SLOT_W-1:0] blocker;

  modport source (output valid, lit, blocker, input ready);
  modport sink   (input valid, lit, blocker, output ready);
endinterface

`default_nettype wire

// ===== sv/rwst_cfg_if.sv =====
// -----------------------------------------------------------------------------
// rwst_cfg_if
// Configuration write channel: register index and write data.
// -----------------------------------------------------------------------------
`default_nettype none

interface rwst_cfg_if import rwst_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/rwst_wall_mem.sv =====
// -----------------------------------------------------------------------------
// rwst_wall_mem
// Wall table: one write port, one read port with a registered read.
// -----------------------------------------------------------------------------
`default_nettype none

module rwst_wall_mem import rwst_pkg::*; (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [SLOT_W-1:0] waddr,
  input  wire logic [WALL_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [SLOT_W-1:0] raddr,
  output logic      [WALL_W-1:0] rdata
);

  logic [WALL_W-1:0] mem [WALLS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/rwst_ray_test.sv =====
// -----------------------------------------------------------------------------
// rwst_ray_test
// Pipelined ray against wall test: differences, products, cross sums, verdict.
// -----------------------------------------------------------------------------
`default_nettype none

module rwst_ray_test import rwst_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    flush,
  input  wire rwst_tag_t               iss_tag,
  input  wire logic [WALL_W-1:0]       wall,
  input  wire logic signed [CRD_W-1:0] px,
  input  wire logic signed [CRD_W-1:0] py,
  input  wire logic signed [DIR_W-1:0] dx,
  input  wire logic signed [DIR_W-1:0] dz,
  output rwst_hit_t                    res
);

  rwst_tag_t tag0_r, tag1_r, tag2_r, tag3_r;
  rwst_hit_t res_r;

  logic signed [CRD_W-1:0] sx, sy, ex, ey;
  logic signed [DIF_W-1:0] dxe, dze;

  logic signed [DIF_W-1:0] a_r, b_r, c_r, d_r;
  logic signed [PRD_W-1:0] p_adx_r, p_bdz_r, p_cdx_r, p_ddz_r, p_ad_r, p_bc_r;
  logic signed [SUM_W-1:0] den_r, tn_r, un_r;
  logic                    hit_nxt;

  // Unpack the table entry, which arrives in the cycle after the read.
  assign sx  = wall[CRD_W-1:0];
  assign sy  = wall[2*CRD_W-1:CRD_W];
  assign ex  = wall[3*CRD_W-1:2*CRD_W];
  assign ey  = wall[4*CRD_W-1:3*CRD_W];
  assign dxe = {dx[DIR_W-1], dx};
  assign dze = {dz[DIR_W-1], dz};

  // Tags follow the data; a flush drops everything in flight.
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      tag0_r.vld <= 1'b0;
      tag1_r.vld <= 1'b0;
      tag2_r.vld <= 1'b0;
      tag3_r.vld <= 1'b0;
      res_r.vld  <= 1'b0;
    end else begin
      tag0_r.vld <= iss_tag.vld;
      tag1_r.vld <= tag0_r.vld;
      tag2_r.vld <= tag1_r.vld;
      tag3_r.vld <= tag2_r.vld;
      res_r.vld  <= tag3_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    tag0_r.last <= iss_tag.last;
    tag0_r.idx  <= iss_tag.idx;
    tag1_r.last <= tag0_r.last;
    tag1_r.idx  <= tag0_r.idx;
    tag2_r.last <= tag1_r.last;
    tag2_r.idx  <= tag1_r.idx;
    tag3_r.last <= tag2_r.last;
    tag3_r.idx  <= tag2_r.idx;
    res_r.last  <= tag3_r.last;
    res_r.idx   <= tag3_r.idx;
  end

  // Stage 1: coordinate differences.
  always_ff @(posedge clk) begin
    a_r <= sdiff(sy, ey);
    b_r <= sdiff(sx, ex);
    c_r <= sdiff(sy, py);
    d_r <= sdiff(sx, px);
  end

  // Stage 2: the six products.
  always_ff @(posedge clk) begin
    p_adx_r <= smul(a_r, dxe);
    p_bdz_r <= smul(b_r, dze);
    p_cdx_r <= smul(c_r, dxe);
    p_ddz_r <= smul(d_r, dze);
    p_ad_r  <= smul(a_r, d_r);
    p_bc_r  <= smul(b_r, c_r);
  end

  // Stage 3: denominator and the two numerators.
  always_ff @(posedge clk) begin
    den_r <= ssub(p_adx_r, p_bdz_r);
    tn_r  <= ssub(p_cdx_r, p_ddz_r);
    un_r  <= ssub(p_ad_r, p_bc_r);
  end

  // Stage 4: the intersection lies on the wall and ahead of the point.
  // A zero denominator means a parallel or degenerate wall.
  always_comb begin
    if (den_r == '0) begin
      hit_nxt = 1'b0;
    end else if (!den_r[SUM_W-1]) begin
      hit_nxt = !tn_r[SUM_W-1] && (tn_r <= den_r) && !un_r[SUM_W-1];
    end else begin
      hit_nxt = (tn_r[SUM_W-1] || (tn_r == '0)) && (tn_r >= den_r) &&
                (un_r[SUM_W-1] || (un_r == '0));
    end
  end

  always_ff @(posedge clk) begin
    res_r.hit <= hit_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== sv/ray_wall_shadow_test_top.sv =====
// -----------------------------------------------------------------------------
// ray_wall_shadow_test_top
// Shadow test of a ground point against a table of wall segments.
// -----------------------------------------------------------------------------
// Usage:
// The input channel carries two kinds of beats. A load beat writes one wall
// into the table slot it names and produces no result.
// A query beat casts a ray from the ground point toward the sun and produces
// one result beat: lit, and the index of the first blocking wall.
// A query reads walls 0 to N-1 from the table memory, one per cycle, and
// feeds them through a five-stage test pipeline (read, differences,
// products, cross sums, verdict). The table memory read port sets the rate:
// a lit query tests all N walls, a blocked query stops at the first blocker,
// and a query with the sun down or with N equal to zero goes straight to
// its result. N is wall_count, saturated to 64.
// One query is in work at a time; the next beat is taken once it finishes.
// The result waits in an output register, so loads and a new query are
// accepted while the receiver stalls; a second finished query then holds
// until that register is free. Reset is synchronous, active low; it clears
// the control state and the configuration, but not the wall table, whose
// entries are undefined until loaded. Configuration writes are always taken.
// -----------------------------------------------------------------------------
`default_nettype none
`include "ray_wall_shadow_test_top_assert.svh"

module ray_wall_shadow_test_top import rwst_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  rwst_in_if.sink   in_ch,
  rwst_out_if.source out_ch,
  rwst_cfg_if.sink  cfg_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // Configuration registers.
  logic signed [DIR_W-1:0] sun_dir_x_r, sun_dir_z_r;
  logic                    sun_up_r;
  logic [CNT_W-1:0]        wall_count_r;

  // Sequencer state.
  logic [1:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        iss_cnt_r, iss_cnt_nxt;
  logic [CNT_W-1:0]        qn_r, qn_nxt;
  logic signed [CRD_W-1:0] px_r, py_r;
  logic                    res_lit_r, res_lit_nxt;
  logic [SLOT_W-1:0]       res_blk_r, res_blk_nxt;
  logic                    out_vld_r, out_vld_nxt;
  logic                    out_lit_r;
  logic [SLOT_W-1:0]       out_blk_r;

  logic              in_acc, cfg_acc, iss_en, flush, out_load;
  logic [CNT_W-1:0]  wall_n;
  logic [WALL_W-1:0] wdata, rdata;
  rwst_tag_t         iss_tag;
  rwst_hit_t         dp_res;

  // Handshakes.
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sun_dir_x_r  <= SUN_DIR_X_RST;
      sun_dir_z_r  <= SUN_DIR_Z_RST;
      sun_up_r     <= 1'b0;
      wall_count_r <= '0;
    end else if (cfg_acc) begin
      case (cfg_ch.index)
        CFG_SUN_DIR_X:  sun_dir_x_r  <= cfg_ch.data;
        CFG_SUN_DIR_Z:  sun_dir_z_r  <= cfg_ch.data;
        CFG_SUN_UP:     sun_up_r     <= cfg_ch.data[0];
        CFG_WALL_COUNT: wall_count_r <= cfg_ch.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Walls tested per query, saturated to the table depth.
  assign wall_n = (wall_count_r > CNT_W'(WALLS)) ? CNT_W'(WALLS) : wall_count_r;

  // Wall table.
  assign wdata = {in_ch.end_y, in_ch.end_x, in_ch.start_y, in_ch.start_x};

  rwst_wall_mem u_mem (
    .clk   (clk),
    .we    (in_acc && (in_ch.opcode == OP_LOAD)),
    .waddr (in_ch.wall_slot),
    .wdata (wdata),
    .re    (iss_en),
    .raddr (iss_cnt_r[SLOT_W-1:0]),
    .rdata (rdata)
  );

  // Issue one wall per cycle while the query runs.
  assign iss_en       = (state_r == ST_RUN) && (iss_cnt_r < qn_r);
  assign iss_tag.vld  = iss_en;
  assign iss_tag.last = (iss_cnt_r == (qn_r - CNT_W'(1)));
  assign iss_tag.idx  = iss_cnt_r[SLOT_W-1:0];

  // The first blocker or the last wall ends the scan.
  assign flush = (state_r == ST_RUN) && dp_res.vld && (dp_res.hit || dp_res.last);

  rwst_ray_test u_test (
    .clk     (clk),
    .rst_n   (rst_n),
    .flush   (flush),
    .iss_tag (iss_tag),
    .wall    (rdata),
    .px      (px_r),
    .py      (py_r),
    .dx      (sun_dir_x_r),
    .dz      (sun_dir_z_r),
    .res     (dp_res)
  );

  // Output register takes the finished result when it is free.
  assign out_load = (state_r == ST_FIN) && (!out_vld_r || out_ch.ready);

  // Query sequencer.
  always_comb begin
    state_nxt   = state_r;
    iss_cnt_nxt = iss_cnt_r;
    qn_nxt      = qn_r;
    res_lit_nxt = res_lit_r;
    res_blk_nxt = res_blk_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.opcode == OP_QUERY)) begin
          iss_cnt_nxt = '0;
          qn_nxt      = wall_n;
          res_blk_nxt = '0;
          if (!sun_up_r) begin
            res_lit_nxt = 1'b0;
            state_nxt   = ST_FIN;
          end else if (wall_n == '0) begin
            res_lit_nxt = 1'b1;
            state_nxt   = ST_FIN;
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (iss_en) begin
          iss_cnt_nxt = iss_cnt_r + CNT_W'(1);
        end
        if (dp_res.vld && dp_res.hit) begin
          res_lit_nxt = 1'b0;
          res_blk_nxt = dp_res.idx;
          state_nxt   = ST_FIN;
        end else if (dp_res.vld && dp_res.last) begin
          res_lit_nxt = 1'b1;
          res_blk_nxt = '0;
          state_nxt   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_cnt_r <= iss_cnt_nxt;
    qn_r      <= qn_nxt;
    res_lit_r <= res_lit_nxt;
    res_blk_r <= res_blk_nxt;
  end

  // Query point is captured with the beat.
  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.opcode == OP_QUERY)) begin
      px_r <= in_ch.point_x;
      py_r <= in_ch.point_y;
    end
  end

  // Result register.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_lit_r <= res_lit_r;
      out_blk_r <= res_blk_r;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.lit     = out_lit_r;
  assign out_ch.blocker = out_blk_r;

  // A result beat only ever comes from a finished query.
  `RWST_ASSERT_IMP(a_out_from_fin, $rose(out_vld_r), $past(state_r) == ST_FIN,
                   "result appeared without a finished query")
  // Nothing leaves the test pipeline outside a running query.
  `RWST_ASSERT_IMP(a_pipe_in_run, dp_res.vld, state_r == ST_RUN,
                   "test pipeline produced a verdict outside a query")
  // The scan end empties the pipeline.
  `RWST_ASSERT_NXT(a_flush_drains, flush, !dp_res.vld,
                   "test pipeline still busy after the scan ended")
  // A blocker found by the scan lies within the tested range.
  `RWST_ASSERT_IMP(a_blk_range,
                   (state_r == ST_FIN) && ($past(state_r) == ST_RUN) && !res_lit_r,
                   {1'b0, res_blk_r} < qn_r,
                   "blocker index outside the tested walls")

endmodule

`default_nettype wire

// ===== tb/sv/tb_ray_wall_shadow_test_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_ray_wall_shadow_test_top
// Self-checking bench for the ray-against-walls shadow test.
// Wall loads and ground point queries go in over the input channel, and a
// local predictor keeps its own copy of the wall table and the sun settings.
// Every result beat is compared with the oldest predicted verdict. Both
// channels idle at random, apart from one back-to-back stretch.
// -----------------------------------------------------------------------------

module tb_ray_wall_shadow_test_top;
  import rwst_pkg::*;

  // Cycles allowed after the last result for the block to settle.
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic                    opcode;
    logic [SLOT_W-1:0]       slot;
    logic signed [CRD_W-1:0] sx;
    logic signed [CRD_W-1:0] sy;
    logic signed [CRD_W-1:0] ex;
    logic signed [CRD_W-1:0] ey;
    logic signed [CRD_W-1:0] px;
    logic signed [CRD_W-1:0] py;
  } shadow_beat_t;

  typedef struct {
    logic signed [CRD_W-1:0] sx;
    logic signed [CRD_W-1:0] sy;
    logic signed [CRD_W-1:0] ex;
    logic signed [CRD_W-1:0] ey;
  } wall_seg_t;

  typedef struct {
    logic              lit;
    logic [SLOT_W-1:0] blocker;
  } shadow_res_t;

  logic clk;
  logic rst_n;

  rwst_in_if  in_ch ();
  rwst_out_if out_ch ();
  rwst_cfg_if cfg_ch ();

  ray_wall_shadow_test_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Local copy of the block's state and settings.
  wall_seg_t               wall_mem [WALLS];
  logic signed [DIR_W-1:0] sun_dx;
  logic signed [DIR_W-1:0] sun_dz;
  logic                    sun_on;
  logic [6:0]              walls_on;

  shadow_res_t shadow_q [$];
  int unsigned bad_count;
  logic        steady_flow;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver side: ready drops in about a third of the cycles.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady_flow || ($urandom_range(99) >= 34);
    end
  end

  // Compare each result beat with the oldest predicted verdict.
  always @(posedge clk) begin
    shadow_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (shadow_q.size() == 0) begin
        if (bad_count < 10)
          $display("unexpected result beat: lit=%0b blocker=%0d", out_ch.lit, out_ch.blocker);
        bad_count++;
      end else begin
        want = shadow_q.pop_front();
        if (out_ch.lit !== want.lit || out_ch.blocker !== want.blocker) begin
          if (bad_count < 10)
            $display("mismatch at %0t: expected lit=%0b blocker=%0d, got lit=%0b blocker=%0d",
                     $realtime, want.lit, want.blocker, out_ch.lit, out_ch.blocker);
          bad_count++;
        end
      end
    end
  end

  // Does the ray from (px, py) toward the sun cross this wall?
  // Signs and cross products stand in for the two divisions.
  function automatic logic wall_in_way(input wall_seg_t w, input longint px,
                                       input longint py);
    longint sx, sy, ex, ey, dx, dz, den, tn, un;
    sx = w.sx;
    sy = w.sy;
    ex = w.ex;
    ey = w.ey;
    dx = sun_dx;
    dz = sun_dz;
    den = (sy - ey) * dx - (sx - ex) * dz;
    tn  = (sy - py) * dx - (sx - px) * dz;
    un  = (sy - ey) * (sx - px) - (sx - ex) * (sy - py);
    // A zero denominator means parallel or degenerate: never blocks.
    if (den == 0)
      return 1'b0;
    if (den > 0)
      return tn >= 0 && tn <= den && un >= 0;
    return tn <= 0 && tn >= den && un <= 0;
  endfunction

  // Verdict for one ground point against the tested part of the table.
  function automatic shadow_res_t predict_shadow(input logic signed [CRD_W-1:0] px,
                                                 input logic signed [CRD_W-1:0] py);
    shadow_res_t r;
    int          n;
    r.lit     = 1'b0;
    r.blocker = '0;
    if (!sun_on)
      return r;
    n = (walls_on > WALLS) ? WALLS : int'(walls_on);
    for (int i = 0; i < n; i++) begin
      if (wall_in_way(wall_mem[i], px, py)) begin
        r.blocker = i[SLOT_W-1:0];
        return r;
      end
    end
    r.lit = 1'b1;
    return r;
  endfunction

  // Coordinate mostly near the origin, sometimes anywhere in range.
  function automatic logic signed [CRD_W-1:0] rand_crd();
    if ($urandom_range(99) < 12)
      return 16'($urandom);
    return 16'(int'($urandom_range(3000)) - 1500);
  endfunction

  function automatic logic signed [DIR_W-1:0] rand_dir();
    case ($urandom_range(9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return 16'($urandom);
      default: return 16'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic shadow_beat_t rand_beat(input int unsigned load_pct);
    shadow_beat_t b;
    b.opcode = ($urandom_range(99) < load_pct) ? OP_LOAD : OP_QUERY;
    b.slot   = SLOT_W'($urandom);
    b.sx     = rand_crd();
    b.sy     = rand_crd();
    case ($urandom_range(19))
      0: begin
        // Zero-length wall.
        b.ex = b.sx;
        b.ey = b.sy;
      end
      1: begin
        b.ex = rand_crd();
        b.ey = b.sy;
      end
      2: begin
        b.ex = b.sx;
        b.ey = rand_crd();
      end
      default: begin
        b.ex = rand_crd();
        b.ey = rand_crd();
      end
    endcase
    b.px = rand_crd();
    b.py = rand_crd();
    return b;
  endfunction

  function automatic shadow_beat_t mk_load(input int slot, input int sx, input int sy,
                                           input int ex, input int ey);
    shadow_beat_t b;
    b        = rand_beat(100);
    b.slot   = SLOT_W'(slot);
    b.sx     = 16'(sx);
    b.sy     = 16'(sy);
    b.ex     = 16'(ex);
    b.ey     = 16'(ey);
    return b;
  endfunction

  function automatic shadow_beat_t mk_query(input int px, input int py);
    shadow_beat_t b;
    b    = rand_beat(0);
    b.px = 16'(px);
    b.py = 16'(py);
    return b;
  endfunction

  // Send one beat, with random idle cycles ahead of it, and predict on accept.
  task automatic send_beat(input shadow_beat_t b);
    if (!steady_flow) begin
      while ($urandom_range(99) < 34) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= b.opcode;
    in_ch.wall_slot <= b.slot;
    in_ch.start_x   <= b.sx;
    in_ch.start_y   <= b.sy;
    in_ch.end_x     <= b.ex;
    in_ch.end_y     <= b.ey;
    in_ch.point_x   <= b.px;
    in_ch.point_y   <= b.py;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (b.opcode == OP_LOAD)
      wall_mem[b.slot] = '{sx: b.sx, sy: b.sy, ex: b.ex, ey: b.ey};
    else
      shadow_q.push_back(predict_shadow(b.px, b.py));
  endtask

  // Stop sending and wait until every verdict is in and the block is quiet.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (shadow_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_SUN_DIR_X:  sun_dx = data;
      CFG_SUN_DIR_Z:  sun_dz = data;
      CFG_SUN_UP:     sun_on = data[0];
      CFG_WALL_COUNT: walls_on = data[6:0];
      default: ;
    endcase
  endtask

  // Write all four registers; unused upper data bits carry noise.
  task automatic set_sun(input logic [DIR_W-1:0] dx, input logic [DIR_W-1:0] dz,
                         input logic up, input logic [6:0] cnt);
    write_reg(CFG_SUN_DIR_X, dx);
    write_reg(CFG_SUN_DIR_Z, dz);
    write_reg(CFG_SUN_UP, {15'($urandom), up});
    write_reg(CFG_WALL_COUNT, {9'($urandom), cnt});
    cfg_ch.valid <= 1'b0;
  endtask

  // Sun down after reset, then sun up with no walls to test.
  task automatic test_sun_down_and_empty();
    send_beat(mk_query(-32768, 32767));
    wait_idle();
    set_sun(16'sd16384, 16'sd0, 1'b1, 7'd0);
    send_beat(mk_query(0, 0));
    wait_idle();
  endtask

  // Hand-built scene with the sun along +x: a zero-length wall, a wall
  // parallel to the ray, one wall ahead and one behind the origin.
  task automatic test_directed_scene();
    send_beat(mk_load(0, 160, 0, 160, 0));
    send_beat(mk_load(1, 0, 800, 16000, 800));
    send_beat(mk_load(2, 8000, -1600, 8000, 1600));
    send_beat(mk_load(3, -8000, -1600, -8000, 1600));
    wait_idle();
    set_sun(16'sd16384, 16'sd0, 1'b1, 7'd4);
    send_beat(mk_query(0, 0));
    send_beat(mk_query(0, 1600));       // ray grazes the wall end point
    send_beat(mk_query(0, 1601));
    send_beat(mk_query(8000, 0));       // point on the wall itself
    send_beat(mk_query(8001, 0));
    send_beat(mk_query(-16000, 0));     // two walls ahead, lower index wins
    send_beat(mk_query(-32768, -32768));
    send_beat(mk_query(32767, 32767));
    wait_idle();
  endtask

  // Full-range diagonal wall, extreme direction, then a zero direction.
  task automatic test_extremes();
    send_beat(mk_load(4, -32768, -32768, 32767, 32767));
    wait_idle();
    set_sun(-16'sd16384, 16'sd16384, 1'b1, 7'd5);
    send_beat(mk_query(32767, -32768));
    send_beat(mk_query(0, 0));
    send_beat(mk_query(-32768, 32767));
    wait_idle();
    set_sun(16'sd0, 16'sd0, 1'b1, 7'd5);
    send_beat(mk_query(-800, 0));
    wait_idle();
  endtask

  // Fill the whole table, then run phases under varied sun settings.
  task automatic test_random_scenes();
    shadow_beat_t b;
    for (int i = 0; i < WALLS; i++) begin
      b      = rand_beat(100);
      b.slot = SLOT_W'(i);
      send_beat(b);
    end
    wait_idle();
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_sun(16'sd16384, 16'sd0, 1'b1, 7'd127);
        1: set_sun(rand_dir(), rand_dir(), 1'b0, 7'd64);
        2: set_sun(16'sd0, 16'sd0, 1'b1, 7'd64);
        3: set_sun(16'h8000, 16'h7FFF, 1'b1, 7'd64);
        4: set_sun(16'sd0, -16'sd16384, 1'b1, 7'd65);
        default: set_sun(rand_dir(), rand_dir(), 1'b1, 7'($urandom_range(1, 64)));
      endcase
      repeat (40) send_beat(rand_beat(30));
      wait_idle();
    end
  endtask

  // Both sides run without idling for a stretch.
  task automatic test_back_to_back();
    set_sun(rand_dir(), rand_dir(), 1'b1, 7'd12);
    steady_flow = 1'b1;
    repeat (60) send_beat(rand_beat(30));
    wait_idle();
    steady_flow = 1'b0;
  endtask

  initial begin
    bad_count   = 0;
    steady_flow = 1'b0;
    sun_dx      = SUN_DIR_X_RST;
    sun_dz      = SUN_DIR_Z_RST;
    sun_on      = 1'b0;
    walls_on    = '0;
    for (int i = 0; i < WALLS; i++)
      wall_mem[i] = '{sx: '0, sy: '0, ex: '0, ey: '0};

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= OP_LOAD;
    in_ch.wall_slot <= '0;
    in_ch.start_x   <= '0;
    in_ch.start_y   <= '0;
    in_ch.end_x     <= '0;
    in_ch.end_y     <= '0;
    in_ch.point_x   <= '0;
    in_ch.point_y   <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_SUN_DIR_X;
    cfg_ch.data     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sun_down_and_empty();
    test_directed_scene();
    test_extremes();
    test_random_scenes();
    test_back_to_back();

    wait_idle();
    if (bad_count == 0 && shadow_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
